### hdl/translation_entry_cache_lru_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the translation entry cache
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef TRANSLATION_ENTRY_CACHE_LRU_UNIT_ASSERT_SVH
`define TRANSLATION_ENTRY_CACHE_LRU_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define TECL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cache assertion failed");
`define TECL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cache assertion failed");
`else
`define TECL_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TECL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/tecl_pkg.sv
// ----------------------------------------------------------------------------
// tecl_pkg
// Types and codes shared by the translation entry cache modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tecl_pkg;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_INVAL  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] virtual_address;
        logic [63:0] root_address;
        logic [63:0] entry_data;
    } t_in_beat;

    typedef struct packed {
        logic        hit;
        logic [63:0] entry_out;
    } t_out_beat;

    typedef struct packed {
        logic [63:0] va;
        logic [63:0] root;
        logic [63:0] data;
        logic [63:0] stamp;
    } t_entry;

    typedef struct packed {
        logic va_eq;
        logic root_eq;
        logic stamp_lt;
    } t_cmp_res;

endpackage

### hdl/tecl_ram.sv
// ----------------------------------------------------------------------------
// tecl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tecl_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/tecl_cmp.sv
// ----------------------------------------------------------------------------
// tecl_cmp
// Shared compare unit: tag equality and stamp ordering for one entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tecl_cmp (
    input  tecl_pkg::t_entry   i_entry,
    input  logic [63:0]        i_va,
    input  logic [63:0]        i_root,
    input  logic [63:0]        i_best_stamp,
    output tecl_pkg::t_cmp_res o_res
);

    import tecl_pkg::*;

    always_comb begin
        o_res.va_eq    = (i_entry.va == i_va);
        o_res.root_eq  = (i_entry.root == i_root);
        o_res.stamp_lt = (i_entry.stamp < i_best_stamp);
    end

endmodule

### hdl/translation_entry_cache_lru_unit.sv
// ----------------------------------------------------------------------------
// translation_entry_cache_lru_unit
// Fully associative page-table entry cache with LRU replacement.
//
//   beat     dir  handshake                 payload
//   in       in   i_in_valid / o_in_stall   i_in_beat  (opcode, tags, data)
//   out      out  o_out_valid / i_out_stall o_out_beat (hit, entry_out)
//
// Entries sit in one RAM and are scanned one per cycle through a single
// compare unit. A lookup stops at its first hit; a miss or an invalidate
// scans every slot. An insert stops at the first free slot, if any.
// An unused opcode goes straight to the result step. Reset clears valid
// bits and the access counter. One result waits in the output register;
// a held result stalls the next item only at its result step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "translation_entry_cache_lru_unit_assert.svh"

module translation_entry_cache_lru_unit #(
    parameter int ENTRIES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tecl_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tecl_pkg::t_out_beat o_out_beat
);

    import tecl_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

    t_state             r_state, n_state;
    t_op                r_op;
    logic [63:0]        r_va, r_root, r_data;
    logic [ENTRIES-1:0] r_valid;
    logic [63:0]        r_cnt;
    logic [IDX_W-1:0]   r_rd_idx, r_chk_idx, r_best_idx;
    logic               r_issue_done, r_chk_vld, r_have_best;
    logic [63:0]        r_best_stamp;
    logic               r_hit;
    logic [63:0]        r_entry;
    logic               r_out_valid;
    t_out_beat          r_out_beat;

    logic               in_acc, out_free;
    logic               chk_vbit, chk_hit, chk_last;
    logic [63:0]        cnt_inc;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    t_entry             ram_wdata, ram_rdata;
    t_cmp_res           cmp;

    tecl_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    tecl_cmp u_cmp (
        .i_entry      (ram_rdata),
        .i_va         (r_va),
        .i_root       (r_root),
        .i_best_stamp (r_best_stamp),
        .o_res        (cmp)
    );

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign chk_vbit = r_valid[r_chk_idx];
    assign chk_hit  = chk_vbit && cmp.va_eq && cmp.root_eq;
    assign chk_last = (r_chk_idx == LAST);
    assign cnt_inc  = r_cnt + 64'd1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (t_op'(i_in_beat.opcode) == OP_NONE) ? ST_RESULT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_chk_vld) begin
                    priority if (r_op == OP_LOOKUP && chk_hit) begin
                        n_state = ST_RESULT;
                    end else if (r_op == OP_INSERT && !chk_vbit) begin
                        n_state = ST_WRITE;
                    end else if (chk_last) begin
                        n_state = (r_op == OP_INSERT) ? ST_WRITE : ST_RESULT;
                    end
                end
            end
            ST_WRITE: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and RAM controls
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        ram_we     = 1'b0;
        ram_waddr  = r_best_idx;
        ram_wdata  = '{va: r_va, root: r_root, data: r_data, stamp: cnt_inc};
        unique case (r_state)
            ST_SCAN: begin
                ram_waddr = r_chk_idx;
                ram_wdata = '{va: r_va, root: r_root, data: ram_rdata.data, stamp: cnt_inc};
                ram_we    = r_chk_vld && (r_op == OP_LOOKUP) && chk_hit;
            end
            ST_WRITE: begin
                ram_we = 1'b1;
            end
            ST_IDLE, ST_RESULT: begin
                ram_we = 1'b0;
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_valid      <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
            r_chk_vld    <= 1'b0;
            r_issue_done <= 1'b0;
            r_have_best  <= 1'b0;
            r_hit        <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_RESULT) && out_free) begin
                r_out_valid <= 1'b1;
                r_out_beat  <= '{hit: r_hit, entry_out: r_entry};
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_op         <= t_op'(i_in_beat.opcode);
                        r_va         <= i_in_beat.virtual_address;
                        r_root       <= i_in_beat.root_address;
                        r_data       <= i_in_beat.entry_data;
                        r_rd_idx     <= '0;
                        r_issue_done <= 1'b0;
                        r_chk_vld    <= 1'b0;
                        r_have_best  <= 1'b0;
                        r_hit        <= 1'b0;
                        r_entry      <= '0;
                    end
                end
                ST_SCAN: begin
                    if (!r_issue_done) begin
                        r_chk_idx <= r_rd_idx;
                        if (r_rd_idx == LAST) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_rd_idx <= r_rd_idx + IDX_W'(1);
                        end
                    end
                    r_chk_vld <= !r_issue_done && (n_state == ST_SCAN);
                    if (r_chk_vld) begin
                        unique case (r_op)
                            OP_LOOKUP: begin
                                if (chk_hit) begin
                                    r_hit   <= 1'b1;
                                    r_entry <= ram_rdata.data;
                                    r_cnt   <= cnt_inc;
                                end
                            end
                            OP_INSERT: begin
                                priority if (!chk_vbit) begin
                                    r_best_idx <= r_chk_idx;
                                end else if (!r_have_best || cmp.stamp_lt) begin
                                    r_best_idx   <= r_chk_idx;
                                    r_best_stamp <= ram_rdata.stamp;
                                    r_have_best  <= 1'b1;
                                end
                            end
                            OP_INVAL: begin
                                if (chk_vbit && cmp.root_eq) begin
                                    r_valid[r_chk_idx] <= 1'b0;
                                end
                            end
                            OP_NONE: begin
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_WRITE: begin
                    r_valid[r_best_idx] <= 1'b1;
                    r_cnt               <= cnt_inc;
                end
                ST_RESULT: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    `TECL_ASSERT_NEXT(a_result_posted, i_clk, i_rst_n, (r_state == ST_RESULT) && out_free, o_out_valid)
    `TECL_ASSERT_NEXT(a_counter_step, i_clk, i_rst_n, 1'b1, (r_cnt == $past(r_cnt)) || (r_cnt == $past(r_cnt) + 64'd1))
    `TECL_ASSERT_NEXT(a_inval_no_set, i_clk, i_rst_n, (r_state == ST_SCAN) && (r_op == OP_INVAL), $countones(r_valid) <= $past($countones(r_valid)))
    `TECL_ASSERT_NEXT(a_insert_sets_valid, i_clk, i_rst_n, r_state == ST_WRITE, r_valid[$past(r_best_idx)])
    `TECL_ASSERT_NOW(a_hit_only_lookup, i_clk, i_rst_n, r_hit, (r_op == OP_LOOKUP))

endmodule
